// File: src/atfb_pkg.sv
`default_nettype none

package atfb_pkg;

    // Frame constants
    localparam logic [7:0]  HdrStart  = 8'h7E;
    localparam logic [7:0]  HdrType   = 8'h10;
    localparam logic [15:0] FixedLen  = 16'd14;
    localparam logic [7:0]  MaxKept   = 8'd237;
    localparam logic [7:0]  TotalBase = 8'd18;
    localparam int          HdrBytes  = 17;
    localparam int          HdrIdxW   = $clog2(HdrBytes);
    localparam logic [HdrIdxW-1:0] HdrLastIdx = HdrIdxW'(HdrBytes - 1);
    // Header index where the running sum starts (type byte)
    localparam logic [HdrIdxW-1:0] HdrSumIdx  = HdrIdxW'(3);

    // Register reset values
    localparam logic [63:0] DestReset  = 64'h0013A200425E92E9;
    localparam logic [7:0]  FidReset   = 8'h01;
    localparam logic [15:0] LimitReset = 16'hFFFF;

    // Configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_DEST  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FID   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LIMIT = 2'd2;

    // Header byte at position idx
    function automatic logic [7:0] hdr_byte(
        input logic [HdrIdxW-1:0] idx,
        input logic [15:0]        len,
        input logic [7:0]         fid,
        input logic [63:0]        dest
    );
        logic [7:0] b;
        case (idx)
            5'd0:    b = HdrStart;
            5'd1:    b = len[15:8];
            5'd2:    b = len[7:0];
            5'd3:    b = HdrType;
            5'd4:    b = fid;
            5'd5:    b = dest[63:56];
            5'd6:    b = dest[55:48];
            5'd7:    b = dest[47:40];
            5'd8:    b = dest[39:32];
            5'd9:    b = dest[31:24];
            5'd10:   b = dest[23:16];
            5'd11:   b = dest[15:8];
            5'd12:   b = dest[7:0];
            5'd13:   b = 8'hFF;
            5'd14:   b = 8'hFE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: src/api_transmit_frame_builder.sv
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// s_        | in        | s_tvalid / s_tready        | s_tdata {payload_len, data_byte}, s_tlast
// m_        | out       | m_tvalid / m_tready        | m_tdata {frame_total, frame_byte}, m_tlast
// cfg_      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One output beat per cycle at most, none while m_ stalls. A kept payload beat
// yields one frame byte; the first beat of a packet is preceded by the 17 header
// bytes, and the beat that closes the frame is followed by the checksum byte. The
// single holding register for the current input beat and the output register set this.
// Reset clears all control state; config registers return to their defaults.
// Backpressure on m_ stalls the holding register, which in turn drops s_tready.

module api_transmit_frame_builder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] payload_len
    input  wire logic        s_tlast,   // last_in
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] frame_byte, [15:8] frame_total
    output logic             m_tlast,   // frame_last
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [atfb_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int IW = atfb_pkg::HdrIdxW;

    // Config registers
    logic [63:0] dest_reg;
    logic [7:0]  fid_reg;
    logic [15:0] limit_reg;

    // Held input beat
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_data_reg;
    logic [15:0] hold_plen_reg;
    logic        hold_last_reg;
    logic [IW-1:0] hdr_idx_reg, hdr_idx_next;
    logic        data_done_reg, data_done_next;

    // Framing state
    logic        in_packet_reg, in_packet_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  target_reg, target_next;
    logic [7:0]  sum_reg, sum_next;
    logic        closed_reg, closed_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [7:0]  out_total_reg, out_total_next;
    logic        out_last_reg, out_last_next;

    // Working signals
    logic        slot_free;
    logic        emit;
    logic        item_done;
    logic        load;
    logic [15:0] t16;
    logic [7:0]  new_target;
    logic [15:0] hdr_len;
    logic [7:0]  hbyte;
    logic        keep;
    logic        close_now;
    logic [7:0]  count_inc;

    assign cfg_ready = 1'b1;

    // Config write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg  <= atfb_pkg::DestReset;
            fid_reg   <= atfb_pkg::FidReset;
            limit_reg <= atfb_pkg::LimitReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                atfb_pkg::CFG_DEST:  dest_reg  <= cfg_data;
                atfb_pkg::CFG_FID:   fid_reg   <= cfg_data[7:0];
                atfb_pkg::CFG_LIMIT: limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Clipped payload length and header length field
    always_comb
    begin
        t16        = (hold_plen_reg < limit_reg) ? hold_plen_reg : limit_reg;
        new_target = (t16 > 16'(atfb_pkg::MaxKept)) ? atfb_pkg::MaxKept : t16[7:0];
        hdr_len    = atfb_pkg::FixedLen + 16'(new_target);
        hbyte      = atfb_pkg::hdr_byte(hdr_idx_reg, hdr_len, fid_reg, dest_reg);
    end

    assign slot_free = !out_valid_reg || m_tready;
    assign count_inc = count_reg + 8'd1;
    assign keep      = !closed_reg && (count_reg < target_reg);

    // Per-cycle step over the held beat
    always_comb
    begin
        in_packet_next  = in_packet_reg;
        count_next      = count_reg;
        target_next     = target_reg;
        sum_next        = sum_reg;
        closed_next     = closed_reg;
        hdr_idx_next    = hdr_idx_reg;
        data_done_next  = data_done_reg;
        emit            = 1'b0;
        item_done       = 1'b0;
        close_now       = 1'b0;
        out_byte_next   = out_byte_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;

        if (hold_valid_reg)
        begin
            if (!in_packet_reg)
            begin
                // Header bytes
                if (slot_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = hbyte;
                    out_last_next = 1'b0;
                    out_total_next = 8'd0;
                    if (hdr_idx_reg < atfb_pkg::HdrSumIdx)
                        sum_next = 8'd0;
                    else
                        sum_next = sum_reg + hbyte;
                    hdr_idx_next = hdr_idx_reg + IW'(1);
                    if (hdr_idx_reg == atfb_pkg::HdrLastIdx)
                    begin
                        in_packet_next = 1'b1;
                        target_next    = new_target;
                        count_next     = 8'd0;
                        closed_next    = 1'b0;
                    end
                end
            end
            else if (!data_done_reg && keep)
            begin
                // Payload byte
                if (slot_free)
                begin
                    emit           = 1'b1;
                    out_byte_next  = hold_data_reg;
                    out_last_next  = 1'b0;
                    out_total_next = 8'd0;
                    sum_next       = sum_reg + hold_data_reg;
                    count_next     = count_inc;
                    data_done_next = 1'b1;
                    if (!((count_inc >= target_reg) || hold_last_reg))
                        item_done = 1'b1;
                end
            end
            else
            begin
                close_now = !closed_reg && ((count_reg >= target_reg) || hold_last_reg);
                if (close_now)
                begin
                    // Checksum byte
                    if (slot_free)
                    begin
                        emit           = 1'b1;
                        out_byte_next  = ~sum_reg;
                        out_last_next  = 1'b1;
                        out_total_next = atfb_pkg::TotalBase + count_reg;
                        closed_next    = 1'b1;
                        item_done      = 1'b1;
                    end
                end
                else
                begin
                    item_done = 1'b1;
                end
            end

            if (item_done && hold_last_reg)
            begin
                in_packet_next = 1'b0;
                closed_next    = 1'b0;
            end
        end
    end

    assign s_tready        = !hold_valid_reg || item_done;
    assign load            = s_tvalid && s_tready;
    assign hold_valid_next = load || (hold_valid_reg && !item_done);
    assign out_valid_next  = emit || (out_valid_reg && !m_tready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hdr_idx_reg    <= '0;
            data_done_reg  <= 1'b0;
            in_packet_reg  <= 1'b0;
            count_reg      <= 8'd0;
            target_reg     <= 8'd0;
            sum_reg        <= 8'd0;
            closed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            in_packet_reg  <= in_packet_next;
            count_reg      <= count_next;
            target_reg     <= target_next;
            sum_reg        <= sum_next;
            closed_reg     <= closed_next;
            out_valid_reg  <= out_valid_next;
            if (load)
            begin
                hdr_idx_reg   <= '0;
                data_done_reg <= 1'b0;
            end
            else
            begin
                hdr_idx_reg   <= hdr_idx_next;
                data_done_reg <= data_done_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_data_reg <= s_tdata[7:0];
            hold_plen_reg <= s_tdata[23:8];
            hold_last_reg <= s_tlast;
        end
        if (emit)
        begin
            out_byte_reg  <= out_byte_next;
            out_total_reg <= out_total_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: tb/atfb_checker.sv
`timescale 1ns / 1ps

module atfb_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] payload_len
    input  wire logic        s_tlast,   // last_in
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] frame_byte, [15:8] frame_total
    input  wire logic        m_tlast,   // frame_last
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [atfb_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               mismatches,
    output int               pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [7:0] total;
    } frame_beat_t;

    // Shadow copies of the config registers
    logic [63:0] dest_reg;
    logic [7:0]  fid_reg;
    logic [15:0] limit_reg;

    // Framing state
    logic        in_pkt;
    logic        closed;
    logic [7:0]  kept_cnt;
    logic [7:0]  kept_tgt;
    logic [7:0]  run_sum;
    int          miss_cnt;

    frame_beat_t frame_q [$];

    function automatic void push_beat(logic [7:0] b, logic lst, logic [7:0] total);
        frame_beat_t beat;
        beat.data  = b;
        beat.last  = lst;
        beat.total = lst ? total : 8'd0;
        frame_q.push_back(beat);
    endfunction

    // Bytes from the type byte onward feed the checksum
    function automatic void push_summed(logic [7:0] b);
        run_sum = run_sum + b;
        push_beat(b, 1'b0, 8'd0);
    endfunction

    // Expected frame beats caused by one payload beat
    function automatic void predict_frame(logic [7:0] d, logic [15:0] plen, logic lst);
        logic [15:0] tgt;
        logic [15:0] len;
        int          k;
        if (!in_pkt)
        begin
            tgt = plen;
            if (tgt > limit_reg)
                tgt = limit_reg;
            if (tgt > {8'd0, atfb_pkg::MaxKept})
                tgt = {8'd0, atfb_pkg::MaxKept};
            kept_tgt = tgt[7:0];
            kept_cnt = 8'd0;
            run_sum  = 8'd0;
            closed   = 1'b0;
            in_pkt   = 1'b1;
            len      = atfb_pkg::FixedLen + tgt;
            push_beat(atfb_pkg::HdrStart, 1'b0, 8'd0);
            push_beat(len[15:8], 1'b0, 8'd0);
            push_beat(len[7:0], 1'b0, 8'd0);
            push_summed(atfb_pkg::HdrType);
            push_summed(fid_reg);
            for (k = 7; k >= 0; k--)
                push_summed(dest_reg[8*k +: 8]);
            push_summed(8'hFF);
            push_summed(8'hFE);
            push_summed(8'h00);
            push_summed(8'h00);
        end
        // Payload byte passes while under the clipped count
        if (!closed && kept_cnt < kept_tgt)
        begin
            push_summed(d);
            kept_cnt = kept_cnt + 8'd1;
        end
        // Checksum closes the frame on full count or early end
        if (!closed && (kept_cnt >= kept_tgt || lst))
        begin
            push_beat(8'hFF - run_sum, 1'b1, atfb_pkg::TotalBase + kept_cnt);
            closed = 1'b1;
        end
        if (lst)
        begin
            in_pkt = 1'b0;
            closed = 1'b0;
        end
    endfunction

    function automatic void report(logic have_want, frame_beat_t want, frame_beat_t got);
        miss_cnt++;
        if (miss_cnt <= REPORT_MAX)
        begin
            if (have_want)
            begin
                $write("%0t: frame beat wrong: expected byte %02h last %0d total %0d, ",
                       $time, want.data, want.last, want.total);
                $display("got byte %02h last %0d total %0d",
                         got.data, got.last, got.total);
            end
            else
            begin
                $display("%0t: frame beat with none pending: byte %02h last %0d total %0d",
                         $time, got.data, got.last, got.total);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t got;
        frame_beat_t want;
        if (!rst_n)
        begin
            dest_reg   = atfb_pkg::DestReset;
            fid_reg    = atfb_pkg::FidReset;
            limit_reg  = atfb_pkg::LimitReset;
            in_pkt     = 1'b0;
            closed     = 1'b0;
            kept_cnt   = 8'd0;
            kept_tgt   = 8'd0;
            run_sum    = 8'd0;
            miss_cnt   = 0;
            frame_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    atfb_pkg::CFG_DEST:  dest_reg  = cfg_data;
                    atfb_pkg::CFG_FID:   fid_reg   = cfg_data[7:0];
                    atfb_pkg::CFG_LIMIT: limit_reg = cfg_data[15:0];
                    default:   ;
                endcase
            end
            // Accepted payload beat
            if (s_tvalid && s_tready)
                predict_frame(s_tdata[7:0], s_tdata[23:8], s_tlast);
            // Accepted frame beat against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.data  = m_tdata[7:0];
                got.last  = m_tlast;
                got.total = m_tdata[15:8];
                if (frame_q.size() == 0)
                    report(1'b0, got, got);
                else
                begin
                    want = frame_q.pop_front();
                    if (want != got)
                        report(1'b1, want, got);
                end
            end
            mismatches <= miss_cnt;
            pending    <= frame_q.size();
        end
    end

endmodule

// File: tb/api_transmit_frame_builder_test.sv
`timescale 1ns / 1ps

module api_transmit_frame_builder_test;

    // Header burst plus checksum, with margin
    localparam int SETTLE_CYCLES = 25;
    // Worst case is well under 10k frame beats
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 10;
    // Unmapped register index, writes are dropped
    localparam logic [atfb_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata   = '0;   // [7:0] data_byte, [23:8] payload_len
    logic               s_tlast   = 1'b0; // last_in
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;          // [7:0] frame_byte, [15:8] frame_total
    logic               m_tlast;          // frame_last
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [atfb_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [63:0]        cfg_data  = '0;

    int mismatches;
    int pending;
    int cycle_count   = 0;
    int src_idle_pct  = 30;
    int sink_idle_pct = 64;

    initial
    begin
        forever #5 clk = ~clk;
    end

    api_transmit_frame_builder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    atfb_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Cycle count and random backpressure on the frame side
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        m_tready    <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One payload beat; valid stays up into the next beat unless a gap is taken
    task automatic send_beat(input logic [7:0] d, input logic [15:0] plen, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {plen, d};
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_packet(input logic [15:0] plen, input int n_items);
        int k;
        for (k = 0; k < n_items; k++)
            send_beat(8'($urandom_range(0, 255)), plen, k == n_items - 1);
    endtask

    task automatic write_reg(input logic [atfb_pkg::CfgIdxW-1:0] idx,
                             input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Wait until every predicted beat has left, then let stray beats settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed packets, some early ends and some with extra bytes
    task automatic run_random(input int budget);
        int          sent;
        int          kind;
        int          n;
        logic [15:0] plen;
        sent = 0;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    plen = 16'($urandom_range(13, 40));
                else
                    plen = 16'($urandom_range(0, 12));
                n = (plen == 0) ? 1 : int'(plen);
            end
            else if (kind < 85)
            begin
                plen = 16'($urandom_range(0, 65535));
                n    = $urandom_range(1, 6);
            end
            else
            begin
                plen = 16'($urandom_range(0, 6));
                n    = int'(plen) + $urandom_range(1, 4);
            end
            send_packet(plen, n);
            sent += n;
        end
    endtask

    initial
    begin
        int ph;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at reset register values
        // empty payload, data byte ignored
        send_beat(8'hFF, 16'd0, 1'b1);
        // plain three-byte payload
        send_beat(8'h00, 16'd3, 1'b0);
        send_beat(8'hFF, 16'd3, 1'b0);
        send_beat(8'h5A, 16'd3, 1'b1);
        // early end before the declared count
        send_beat(8'hA5, 16'd5, 1'b0);
        send_beat(8'h3C, 16'd5, 1'b1);
        // extra bytes after the frame closed
        send_beat(8'h01, 16'd2, 1'b0);
        send_beat(8'h80, 16'd2, 1'b0);
        send_beat(8'h7F, 16'd2, 1'b0);
        send_beat(8'hFE, 16'd2, 1'b1);
        // empty payload followed by ignored bytes
        send_beat(8'h11, 16'd0, 1'b0);
        send_beat(8'h22, 16'd0, 1'b0);
        send_beat(8'h33, 16'd0, 1'b1);
        // largest declared length, clipped, closed at once
        send_beat(8'hC3, 16'hFFFF, 1'b1);

        for (ph = 0; ph < PHASES; ph++)
        begin
            src_idle_pct  = (ph < 2) ? 30 : (ph < 4) ? 64 : 0;
            sink_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 30 : 0;
            drain();
            case (ph)
                0:
                begin
                    write_reg(atfb_pkg::CFG_DEST, 64'd0);
                    write_reg(atfb_pkg::CFG_FID, 64'd0);
                    write_reg(atfb_pkg::CFG_LIMIT, 64'd0);
                end
                1:
                begin
                    write_reg(atfb_pkg::CFG_DEST, {$urandom, $urandom});
                    write_reg(atfb_pkg::CFG_FID, 64'($urandom_range(0, 255)));
                    write_reg(atfb_pkg::CFG_LIMIT, 64'($urandom_range(1, 12)));
                end
                2:
                begin
                    write_reg(atfb_pkg::CFG_DEST, {64{1'b1}});
                    write_reg(atfb_pkg::CFG_FID, 64'hFF);
                    write_reg(atfb_pkg::CFG_LIMIT, 64'hFFFF);
                end
                3:
                begin
                    write_reg(atfb_pkg::CFG_DEST, {$urandom, $urandom});
                    write_reg(atfb_pkg::CFG_FID, 64'($urandom_range(0, 255)));
                    write_reg(atfb_pkg::CFG_LIMIT, 64'($urandom_range(236, 238)));
                end
                4:
                begin
                    write_reg(atfb_pkg::CFG_DEST, {$urandom, $urandom});
                    write_reg(atfb_pkg::CFG_FID, 64'($urandom_range(0, 255)));
                    write_reg(atfb_pkg::CFG_LIMIT, 64'($urandom_range(0, 40)));
                end
                default:
                begin
                    write_reg(atfb_pkg::CFG_DEST, {$urandom, $urandom});
                    write_reg(atfb_pkg::CFG_FID, 64'($urandom_range(0, 255)));
                    write_reg(atfb_pkg::CFG_LIMIT, 64'($urandom_range(0, 65535)));
                end
            endcase
            write_reg(CFG_SPARE, {$urandom, $urandom});
            cfg_valid <= 1'b0;
            // largest frame: 237 kept bytes
            if (ph == 2)
                send_packet(16'd300, 237);
            run_random(PHASE_ITEMS);
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
